// File: rtl/core/psc_pkg.sv
package psc_pkg;

  localparam int LOG_DEPTH = 1024;
  localparam int LOG_AW    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

  localparam logic [31:0] HEADER_MAGIC = 32'h31f7_1dc1;
  localparam logic [1:0]  CE_MASK      = 2'h3;
  localparam logic [31:0] LOG_LIMIT    = 32'(LOG_DEPTH);

  localparam logic [10:0] COUNT_RESET  = 11'd32;

  localparam logic ACT_PACKET = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  localparam logic CFG_COOKIE = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  localparam logic [1:0] ST_ACCEPTED  = 2'd0;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
  localparam logic [1:0] ST_BAD_COOKIE = 2'd2;
  localparam logic [1:0] ST_LOG_READ  = 2'd3;

  typedef struct packed {
    logic        seen;
    logic [7:0]  tos;
  } log_entry_t;

  typedef struct packed {
    logic              en;
    logic [LOG_AW-1:0] addr;
    log_entry_t        data;
  } log_wr_t;

  typedef struct packed {
    logic        action;
    logic [31:0] magic_word;
    logic [31:0] packet_cookie;
    logic [31:0] sequence_req;
    logic        tos_present;
    logic [7:0]  tos_byte;
    logic [9:0]  read_index;
  } psc_item_t;

  function automatic logic [LOG_AW-1:0] log_addr(input logic [31:0] x);
    return x[LOG_AW-1:0];
  endfunction

endpackage

// File: rtl/core/psc_log_mem.sv
module psc_log_mem
  import psc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [LOG_AW-1:0] rd_addr,
  input  log_wr_t           wr,
  output log_entry_t        rd_data,
  output logic              clr_busy
);

  log_entry_t        mem [LOG_DEPTH];
  log_entry_t        rd_data_r;
  logic [LOG_AW-1:0] rd_addr_r;
  logic              clr_busy_r;
  logic [LOG_AW-1:0] clr_addr_r;
  logic              fwd_valid_r;
  logic [LOG_AW-1:0] fwd_addr_r;
  log_entry_t        fwd_data_r;

  // sweep the log once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == LOG_AW'(LOG_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // hold the latest write to cover a read issued on the same edge
  always_ff @(posedge clk) begin
    if (!rst_n || clr_busy_r) begin
      fwd_valid_r <= 1'b0;
    end else if (wr.en) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      fwd_addr_r <= wr.addr;
      fwd_data_r <= wr.data;
    end
  end

  assign rd_data  = (fwd_valid_r && (fwd_addr_r == rd_addr_r)) ? fwd_data_r : rd_data_r;
  assign clr_busy = clr_busy_r;

  a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> (!rd_en && !wr.en))
    else $error("log accessed during clearing pass");

endmodule

// File: rtl/core/psc_proc.sv
module psc_proc
  import psc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s1_valid,
  input  psc_item_t   s1_item,
  input  log_entry_t  old_entry,
  input  logic [31:0] expected_cookie,
  input  logic [10:0] expected_count,
  output logic        s1_fire,
  output log_wr_t     wr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_received_count,
  output logic [31:0] out_in_order_count,
  output logic [31:0] out_out_of_order_count,
  output logic [31:0] out_duplicate_count,
  output logic [31:0] out_congestion_count,
  output logic        out_entry_seen,
  output logic [7:0]  out_entry_tos
);

  logic [31:0] total_r, total_nxt;
  logic [31:0] last_r, last_nxt;
  logic [31:0] prefix_r, prefix_nxt;
  logic [31:0] disorder_r, disorder_nxt;
  logic [31:0] repeat_r, repeat_nxt;
  logic [31:0] marked_r, marked_nxt;
  logic        out_valid_r;
  logic [1:0]  status_r, status_nxt;
  logic        seen_r, seen_nxt;
  logic [7:0]  tos_r, tos_nxt;

  logic is_read, pkt_ok, started, ce, log_it, rd_in_range;
  logic [31:0] seq;

  assign s1_fire     = s1_valid && (!out_valid_r || out_ready);
  assign seq         = s1_item.sequence_req;
  assign is_read     = (s1_item.action == ACT_READ);
  assign pkt_ok      = !is_read && (s1_item.magic_word == HEADER_MAGIC) &&
                       (s1_item.packet_cookie == expected_cookie);
  assign started     = (total_r != 32'd0);
  assign ce          = s1_item.tos_present && ((s1_item.tos_byte[1:0] & CE_MASK) == CE_MASK);
  assign log_it      = (seq < 32'(expected_count)) && (seq < LOG_LIMIT);
  assign rd_in_range = (32'(s1_item.read_index) < LOG_LIMIT);

  always_comb begin
    total_nxt    = total_r;
    last_nxt     = last_r;
    prefix_nxt   = prefix_r;
    disorder_nxt = disorder_r;
    repeat_nxt   = repeat_r;
    marked_nxt   = marked_r;
    seen_nxt     = 1'b0;
    tos_nxt      = 8'd0;
    if (is_read) begin
      status_nxt = ST_LOG_READ;
      if (rd_in_range) begin
        seen_nxt = old_entry.seen;
        tos_nxt  = old_entry.tos;
      end
    end else if (s1_item.magic_word != HEADER_MAGIC) begin
      status_nxt = ST_BAD_MAGIC;
    end else if (s1_item.packet_cookie != expected_cookie) begin
      status_nxt = ST_BAD_COOKIE;
    end else begin
      status_nxt = ST_ACCEPTED;
      if (ce) begin
        marked_nxt = marked_r + 32'd1;
      end
      if (started && (seq < last_r)) begin
        disorder_nxt = disorder_r + 32'd1;
      end
      if (started && (seq == last_r)) begin
        repeat_nxt = repeat_r + 32'd1;
      end
      if ((repeat_nxt == 32'd0) && (disorder_nxt == 32'd0) && (seq == prefix_r)) begin
        prefix_nxt = prefix_r + 32'd1;
      end
      total_nxt = total_r + 32'd1;
      last_nxt  = seq;
    end
  end

  always_comb begin
    wr.en        = s1_fire && pkt_ok && log_it;
    wr.addr      = log_addr(seq);
    wr.data.seen = 1'b1;
    wr.data.tos  = s1_item.tos_present ? s1_item.tos_byte : old_entry.tos;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= '0;
      last_r     <= '0;
      prefix_r   <= '0;
      disorder_r <= '0;
      repeat_r   <= '0;
      marked_r   <= '0;
    end else if (s1_fire) begin
      total_r    <= total_nxt;
      last_r     <= last_nxt;
      prefix_r   <= prefix_nxt;
      disorder_r <= disorder_nxt;
      repeat_r   <= repeat_nxt;
      marked_r   <= marked_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      status_r <= status_nxt;
      seen_r   <= seen_nxt;
      tos_r    <= tos_nxt;
    end
  end

  // counters in the result register are taken after the update
  logic [31:0] res_total_r, res_prefix_r, res_disorder_r, res_repeat_r, res_marked_r;

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_total_r    <= total_nxt;
      res_prefix_r   <= prefix_nxt;
      res_disorder_r <= disorder_nxt;
      res_repeat_r   <= repeat_nxt;
      res_marked_r   <= marked_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = status_r;
  assign out_received_count     = res_total_r;
  assign out_in_order_count     = res_prefix_r;
  assign out_out_of_order_count = res_disorder_r;
  assign out_duplicate_count    = res_repeat_r;
  assign out_congestion_count   = res_marked_r;
  assign out_entry_seen         = seen_r;
  assign out_entry_tos          = tos_r;

  a_prefix_needs_order: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (prefix_r != $past(prefix_r))) |->
      ((repeat_r == 32'd0) && (disorder_r == 32'd0)))
    else $error("in-order prefix advanced after disorder");

  a_total_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (total_r != $past(total_r))) |->
      (total_r == $past(total_r) + 32'd1))
    else $error("received count moved by more than one");

  a_entry_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != ST_LOG_READ)) |-> (!seen_r && (tos_r == 8'd0)))
    else $error("log fields set on a non-read result");

endmodule

// File: rtl/core/packet_sequence_checker.sv
// Receive-side sequence checker: one item (packet header or log read) per clock
// when the result side keeps up; a taken item is held in the stage register and its
// result then in the result register, and a stalled result holds back the stage.
// The arrival log sits in a single-port-write RAM read as the item is taken; the
// update stage writes back the entry and a forwarding register covers a read
// of the entry written on the same edge. After reset the log is swept to zero,
// entry by entry, and no item is taken until the sweep ends; configuration
// writes are taken throughout.
module packet_sequence_checker
  import psc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [31:0] in_magic_word,
  input  logic [31:0] in_packet_cookie,
  input  logic [31:0] in_sequence_req,
  input  logic        in_tos_present,
  input  logic [7:0]  in_tos_byte,
  input  logic [9:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_received_count,
  output logic [31:0] out_in_order_count,
  output logic [31:0] out_out_of_order_count,
  output logic [31:0] out_duplicate_count,
  output logic [31:0] out_congestion_count,
  output logic        out_entry_seen,
  output logic [7:0]  out_entry_tos
);

  logic [31:0]       cookie_r;
  logic [10:0]       count_r;
  logic              s1_valid_r;
  psc_item_t         s1_item_r;
  logic              s1_fire;
  logic              in_accept;
  logic              clr_busy;
  logic [LOG_AW-1:0] rd_addr;
  log_entry_t        old_entry;
  log_wr_t           wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cookie_r <= '0;
      count_r  <= COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COOKIE: cookie_r <= cfg_wdata;
        CFG_COUNT:  count_r  <= cfg_wdata[10:0];
        default:    cookie_r <= cookie_r;
      endcase
    end
  end

  assign in_ready  = !clr_busy && (!s1_valid_r || s1_fire);
  assign in_accept = in_valid && in_ready;
  assign rd_addr   = (in_action == ACT_READ) ? log_addr(32'(in_read_index))
                                             : log_addr(in_sequence_req);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.action        <= in_action;
      s1_item_r.magic_word    <= in_magic_word;
      s1_item_r.packet_cookie <= in_packet_cookie;
      s1_item_r.sequence_req  <= in_sequence_req;
      s1_item_r.tos_present   <= in_tos_present;
      s1_item_r.tos_byte      <= in_tos_byte;
      s1_item_r.read_index    <= in_read_index;
    end
  end

  psc_log_mem u_log_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .rd_data  (old_entry),
    .clr_busy (clr_busy)
  );

  psc_proc u_proc (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .s1_valid               (s1_valid_r),
    .s1_item                (s1_item_r),
    .old_entry              (old_entry),
    .expected_cookie        (cookie_r),
    .expected_count         (count_r),
    .s1_fire                (s1_fire),
    .wr                     (wr),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_received_count     (out_received_count),
    .out_in_order_count     (out_in_order_count),
    .out_out_of_order_count (out_out_of_order_count),
    .out_duplicate_count    (out_duplicate_count),
    .out_congestion_count   (out_congestion_count),
    .out_entry_seen         (out_entry_seen),
    .out_entry_tos          (out_entry_tos)
  );

endmodule

// File: tb/packet_sequence_checker_tb.sv
module packet_sequence_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned LONG_HOLD   = 400;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] received;
    logic [31:0] in_order;
    logic [31:0] misordered;
    logic [31:0] duplicates;
    logic [31:0] congestion;
    logic        seen;
    logic [7:0]  tos;
  } report_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_COOKIE;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_action = ACT_PACKET;
  logic [31:0] in_magic_word = '0;
  logic [31:0] in_packet_cookie = '0;
  logic [31:0] in_sequence_req = '0;
  logic        in_tos_present = 1'b0;
  logic [7:0]  in_tos_byte = '0;
  logic [9:0]  in_read_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_received_count;
  logic [31:0] out_in_order_count;
  logic [31:0] out_out_of_order_count;
  logic [31:0] out_duplicate_count;
  logic [31:0] out_congestion_count;
  logic        out_entry_seen;
  logic [7:0]  out_entry_tos;

  packet_sequence_checker uut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_action              (in_action),
    .in_magic_word          (in_magic_word),
    .in_packet_cookie       (in_packet_cookie),
    .in_sequence_req        (in_sequence_req),
    .in_tos_present         (in_tos_present),
    .in_tos_byte            (in_tos_byte),
    .in_read_index          (in_read_index),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_received_count     (out_received_count),
    .out_in_order_count     (out_in_order_count),
    .out_out_of_order_count (out_out_of_order_count),
    .out_duplicate_count    (out_duplicate_count),
    .out_congestion_count   (out_congestion_count),
    .out_entry_seen         (out_entry_seen),
    .out_entry_tos          (out_entry_tos)
  );

  // predictor copy of the checker state and its settings
  logic [31:0] cookie_reg = '0;
  logic [10:0] count_reg  = COUNT_RESET;
  logic [31:0] rx_total, last_seq, prefix_len, disorder, repeats, ce_marks;
  logic        log_seen [LOG_DEPTH];
  logic [7:0]  log_tos  [LOG_DEPTH];

  report_t     expected_reports [$];
  psc_item_t   pending_items [$];
  psc_item_t   held_item;
  report_t     want_report;

  int unsigned items_queued   = 0;
  int unsigned items_accepted = 0;
  int unsigned rejected_count = 0;
  int unsigned reads_count    = 0;
  int unsigned settings_used  = 0;
  int unsigned mismatches     = 0;
  int unsigned gap_left       = 0;
  int unsigned burst_left     = 0;
  int unsigned stall_left     = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;
  bit          hold_armed     = 1'b0;
  logic [31:0] burst_seq      = '0;
  logic [31:0] last_issued    = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic predict_report(input psc_item_t it);
    report_t r;
    r = '0;
    if (it.action == ACT_READ) begin
      r.status = ST_LOG_READ;
      if (32'(it.read_index) < LOG_LIMIT) begin
        r.seen = log_seen[it.read_index];
        r.tos  = log_tos[it.read_index];
      end
      reads_count++;
    end else if (it.magic_word != HEADER_MAGIC) begin
      r.status = ST_BAD_MAGIC;
      rejected_count++;
    end else if (it.packet_cookie != cookie_reg) begin
      r.status = ST_BAD_COOKIE;
      rejected_count++;
    end else begin
      r.status = ST_ACCEPTED;
      if (it.sequence_req < {21'b0, count_reg} && it.sequence_req < LOG_LIMIT) begin
        log_seen[it.sequence_req[LOG_AW-1:0]] = 1'b1;
        if (it.tos_present)
          log_tos[it.sequence_req[LOG_AW-1:0]] = it.tos_byte;
      end
      if (it.tos_present && (it.tos_byte[1:0] & CE_MASK) == CE_MASK)
        ce_marks++;
      if (rx_total != 0 && it.sequence_req < last_seq)
        disorder++;
      if (rx_total != 0 && it.sequence_req == last_seq)
        repeats++;
      if (repeats == 0 && disorder == 0 && it.sequence_req == prefix_len)
        prefix_len++;
      rx_total++;
      last_seq = it.sequence_req;
    end
    r.received     = rx_total;
    r.in_order     = prefix_len;
    r.misordered   = disorder;
    r.duplicates   = repeats;
    r.congestion   = ce_marks;
    expected_reports.push_back(r);
  endtask

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, label, want, got);
      mismatches++;
    end
  endtask

  // driver: bursts of items with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_report(held_item);
        items_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          held_item = pending_items.pop_front();
          in_action        <= held_item.action;
          in_magic_word    <= held_item.magic_word;
          in_packet_cookie <= held_item.packet_cookie;
          in_sequence_req  <= held_item.sequence_req;
          in_tos_present   <= held_item.tos_present;
          in_tos_byte      <= held_item.tos_byte;
          in_read_index    <= held_item.read_index;
          in_valid         <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result, stall on a pattern of its own
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Test completed with failures");
      $finish;
    end
    if (out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, out_status);
        mismatches++;
      end else begin
        want_report = expected_reports.pop_front();
        check_field("status", 32'(want_report.status), 32'(out_status));
        check_field("received_count", want_report.received, out_received_count);
        check_field("in_order_count", want_report.in_order, out_in_order_count);
        check_field("out_of_order_count", want_report.misordered,
                    out_out_of_order_count);
        check_field("duplicate_count", want_report.duplicates, out_duplicate_count);
        check_field("congestion_count", want_report.congestion, out_congestion_count);
        check_field("entry_seen", 32'(want_report.seen), 32'(out_entry_seen));
        check_field("entry_tos", 32'(want_report.tos), 32'(out_entry_tos));
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_armed && out_valid) begin
      hold_armed = 1'b0;
      hold_left  = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      case (cycle_count[9:8])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= 1'($urandom_range(0, 1));
        2'd2: out_ready <= (cycle_count[1:0] != 2'd0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  task automatic write_config(input logic [31:0] cookie, input logic [10:0] count);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COOKIE;
    cfg_wdata <= cookie;
    @(posedge clk);
    cfg_index <= CFG_COUNT;
    cfg_wdata <= {21'b0, count};
    cookie_reg = cookie;
    @(posedge clk);
    cfg_we <= 1'b0;
    count_reg = count;
    burst_seq = '0;
    settings_used++;
  endtask

  task automatic queue_item(input psc_item_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic wait_idle();
    while (items_accepted != items_queued || expected_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic psc_item_t packet(input logic [31:0] seq, input logic tos_on,
                                       input logic [7:0] tos);
    psc_item_t it;
    it.action        = ACT_PACKET;
    it.magic_word    = HEADER_MAGIC;
    it.packet_cookie = cookie_reg;
    it.sequence_req  = seq;
    it.tos_present   = tos_on;
    it.tos_byte      = tos;
    it.read_index    = 10'($urandom);
    return it;
  endfunction

  function automatic psc_item_t log_read(input logic [9:0] idx);
    psc_item_t it;
    it = packet($urandom, 1'($urandom_range(0, 1)), 8'($urandom));
    it.action        = ACT_READ;
    it.magic_word    = $urandom;
    it.packet_cookie = $urandom;
    it.read_index    = idx;
    return it;
  endfunction

  function automatic psc_item_t random_item();
    psc_item_t   it;
    int unsigned pick;
    int unsigned window;
    window = (count_reg == 0) ? 64 : count_reg;
    it = packet($urandom_range(0, window), ($urandom_range(0, 4) != 0), 8'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      it = log_read(10'($urandom));
      if ($urandom_range(0, 1))
        it.read_index = 10'($urandom_range(0, window - 1));
    end else if (pick < 20) begin
      it.magic_word = $urandom_range(0, 1) ? $urandom
                                           : HEADER_MAGIC ^ (32'h1 << $urandom_range(0, 31));
      it.packet_cookie = $urandom;
    end else if (pick < 25) begin
      it.packet_cookie = cookie_reg ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF
                                                             : 32'h1 << $urandom_range(0, 31));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        it.sequence_req = burst_seq;
        burst_seq = (burst_seq + 1 >= window) ? '0 : burst_seq + 1;
      end else if (pick < 80) begin
        it.sequence_req = last_issued;
      end else if (pick < 90) begin
        it.sequence_req = $urandom_range(0, last_issued);
      end else begin
        it.sequence_req = $urandom_range(0, 1) ? $urandom : LOG_LIMIT + $urandom_range(0, 15);
      end
      last_issued = it.sequence_req;
    end
    return it;
  endfunction

  task automatic random_phase(input logic [31:0] cookie, input logic [10:0] count,
                              input int unsigned n);
    write_config(cookie, count);
    repeat (n) queue_item(random_item());
    wait_idle();
  endtask

  initial begin
    rx_total   = '0;
    last_seq   = '0;
    prefix_len = '0;
    disorder   = '0;
    repeats    = '0;
    ce_marks   = '0;
    for (int i = 0; i < LOG_DEPTH; i++) begin
      log_seen[i] = 1'b0;
      log_tos[i]  = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    write_config($urandom, 11'd1024);
    queue_item(log_read(10'd0));
    queue_item(packet(32'd0, 1'b1, 8'h00) ^ {1'b0, ~HEADER_MAGIC ^ HEADER_MAGIC, 32'h0,
                                             32'h0, 1'b0, 8'h0, 10'h0});
    begin
      psc_item_t it;
      it = packet(32'd0, 1'b1, 8'h03);
      it.magic_word = ~HEADER_MAGIC;
      queue_item(it);
      it.packet_cookie = ~cookie_reg;
      it.magic_word    = '0;
      queue_item(it);
      it = packet(32'd0, 1'b1, 8'h03);
      it.packet_cookie = cookie_reg ^ 32'h8000_0000;
      queue_item(it);
    end
    queue_item(packet(32'd0, 1'b1, 8'h03));
    queue_item(packet(32'd1, 1'b1, 8'h02));
    queue_item(packet(32'd2, 1'b0, 8'hFF));
    queue_item(packet(32'd3, 1'b1, 8'hFF));
    queue_item(log_read(10'd2));
    queue_item(packet(32'd3, 1'b1, 8'h00));
    queue_item(packet(32'd4, 1'b1, 8'h7F));
    queue_item(packet(32'd1, 1'b0, 8'h03));
    queue_item(log_read(10'd1));
    queue_item(packet(32'hFFFF_FFFF, 1'b1, 8'hAA));
    queue_item(packet(32'd1023, 1'b1, 8'h55));
    queue_item(packet(32'd1024, 1'b1, 8'hFF));
    queue_item(log_read(10'h3FF));
    queue_item(log_read(10'd3));
    wait_idle();

    write_config(32'hFFFF_FFFF, 11'd0);
    queue_item(packet(32'd0, 1'b1, 8'hC3));
    queue_item(log_read(10'd0));
    queue_item(log_read(10'd5));
    begin
      psc_item_t it;
      it = packet(32'd6, 1'b1, 8'h01);
      it.packet_cookie = '0;
      queue_item(it);
    end
    wait_idle();

    hold_armed = 1'b1;
    random_phase($urandom, 11'd1024, 300);
    random_phase(32'h0, 11'd0, 200);
    random_phase(32'hFFFF_FFFF, 11'd1, 300);
    random_phase($urandom, 11'($urandom_range(2, 1023)), 400);
    repeat (8) @(posedge clk);

    $display("Covered %0d items: %0d packets taken, %0d rejected, %0d log reads",
             items_accepted, rx_total, rejected_count, reads_count);
    $display("Over %0d register settings, with one %0d-cycle result hold-off",
             settings_used, LONG_HOLD);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/psc_pkg.sv
rtl/core/psc_log_mem.sv
rtl/core/psc_proc.sv
rtl/core/packet_sequence_checker.sv
tb/packet_sequence_checker_tb.sv
